// File: src/gsrc_pkg.sv
// Shared constants and types for the gimbal stick rate control block.
// No dependencies; every module of the block and its testbench import this package.
package gsrc_pkg;

    // Tick modes carried in the mode field of a request.
    typedef enum logic [1:0] {
        MODE_HOLD     = 2'd0,
        MODE_HOME     = 2'd1,
        MODE_PAN_TILT = 2'd2,
        MODE_PAN_ONLY = 2'd3
    } mode_t;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 3;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    localparam cfg_index_t REG_STICK_CENTER  = 3'd0;
    localparam cfg_index_t REG_ZONE_SMALL    = 3'd1;
    localparam cfg_index_t REG_ZONE_MEDIUM   = 3'd2;
    localparam cfg_index_t REG_PAN_MIN       = 3'd3;
    localparam cfg_index_t REG_PAN_MAX       = 3'd4;
    localparam cfg_index_t REG_TILT_MIN      = 3'd5;
    localparam cfg_index_t REG_TILT_MAX      = 3'd6;
    localparam cfg_index_t REG_HOME_POSITION = 3'd7;

    // Register reset values (truncated to the configured widths where used).
    localparam int RST_STICK_CENTER  = 1024;
    localparam int RST_ZONE_SMALL    = 220;
    localparam int RST_ZONE_MEDIUM   = 440;
    localparam int RST_PAN_MIN       = 500;
    localparam int RST_PAN_MAX       = 2250;
    localparam int RST_TILT_MIN      = 1000;
    localparam int RST_TILT_MAX      = 2100;
    localparam int RST_HOME_POSITION = 1350;

    // Step sizes per deflection zone.
    localparam int STEP_BITS      = 6;
    localparam int STEP_SLOW      = 3;
    localparam int PAN_STEP_MED   = 18;
    localparam int PAN_STEP_FAST  = 50;
    localparam int TILT_STEP_MED  = 10;
    localparam int TILT_STEP_FAST = 18;

endpackage

// File: src/gsrc_req_if.sv
// Request channel of the gimbal stick rate control block: mode and two sticks.
// Depends on nothing; the width follows the STICK_BITS parameter.
interface gsrc_req_if #(
    parameter int STICK_BITS = 11
);
    logic                  valid;
    logic                  ready;
    logic [1:0]            mode;
    logic [STICK_BITS-1:0] pan_stick;
    logic [STICK_BITS-1:0] tilt_stick;

    modport source (output valid, output mode, output pan_stick, output tilt_stick,
                    input ready);
    modport sink   (input valid, input mode, input pan_stick, input tilt_stick,
                    output ready);
endinterface

// File: src/gsrc_rsp_if.sv
// Result channel of the gimbal stick rate control block: both positions and a flag.
// Depends on nothing; the width follows the POSITION_BITS parameter.
interface gsrc_rsp_if #(
    parameter int POSITION_BITS = 12
);
    logic                     valid;
    logic                     ready;
    logic [POSITION_BITS-1:0] pan_position;
    logic [POSITION_BITS-1:0] tilt_position;
    logic                     position_updated;

    modport source (output valid, output pan_position, output tilt_position,
                    output position_updated, input ready);
    modport sink   (input valid, input pan_position, input tilt_position,
                    input position_updated, output ready);
endinterface

// File: src/gimbal_stick_rate_control.sv
// Top level of the gimbal stick rate control block.
// Depends on gsrc_pkg, gsrc_req_if, gsrc_rsp_if, gsrc_cfg_regs and gsrc_axis.
//
// Each request (one control tick) carries a mode and a pan and a tilt stick
// reading; the block keeps the pan and tilt servo positions and answers every
// request with exactly one result: both positions after the tick and a flag
// that is high when a new servo command would go out. Hold mode keeps both
// positions, home mode loads home_position into both, pan-and-tilt mode steers
// both axes and pan-only mode steers pan. The step is 3, a medium step or a
// fast step depending on the stick's deflection from stick_center against
// zone_small and zone_medium, and moves are clamped to each axis's limits.
// The block has two register stages: a request register and a result
// register, with the step, clamp and state update between them. It accepts
// one request per cycle while the result side does not stall; each request
// goes through both registers in turn. The request stage loads whenever it is
// empty or moves on, and it moves into the result register whenever that is
// empty or being taken, so the block only stalls while the result side stalls.
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_data
// and take effect on the next tick; write them only while the block is idle.
module gimbal_stick_rate_control #(
    parameter int STICK_BITS    = 11,
    parameter int POSITION_BITS = 12
) (
    input  logic                                clk,
    input  logic                                rst_n,
    gsrc_req_if.sink                            req,
    gsrc_rsp_if.source                          rsp,
    input  logic                                cfg_wr_en,
    input  logic [gsrc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [((STICK_BITS > POSITION_BITS) ? STICK_BITS : POSITION_BITS)-1:0] cfg_data
);
    import gsrc_pkg::*;

    localparam int DATA_BITS = (STICK_BITS > POSITION_BITS) ? STICK_BITS : POSITION_BITS;

    // Configuration values.
    logic [STICK_BITS-1:0]    stick_center, zone_small, zone_medium;
    logic [POSITION_BITS-1:0] pan_min, pan_max, tilt_min, tilt_max, home_position;

    // Request stage.
    logic                  req_vld_reg;
    mode_t                 mode_reg;
    logic [STICK_BITS-1:0] pan_stick_reg, tilt_stick_reg;

    // Servo state.
    logic [POSITION_BITS-1:0] pan_now_reg, tilt_now_reg;
    logic [POSITION_BITS-1:0] pan_now_next, tilt_now_next;

    // Result stage.
    logic                     rsp_vld_reg;
    logic [POSITION_BITS-1:0] pan_pos_reg, tilt_pos_reg;
    logic                     updated_reg;
    logic                     updated_next;

    // Pipeline control.
    logic rsp_adv;
    logic fire;

    // Axis step outputs.
    logic                     pan_en, tilt_en;
    logic [POSITION_BITS-1:0] pan_step_pos, tilt_step_pos;
    logic                     pan_moved, tilt_moved;

    gsrc_cfg_regs #(
        .STICK_BITS    (STICK_BITS),
        .POSITION_BITS (POSITION_BITS),
        .DATA_BITS     (DATA_BITS)
    ) u_cfg_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .stick_center  (stick_center),
        .zone_small    (zone_small),
        .zone_medium   (zone_medium),
        .pan_min       (pan_min),
        .pan_max       (pan_max),
        .tilt_min      (tilt_min),
        .tilt_max      (tilt_max),
        .home_position (home_position)
    );

    // Advance the result register when it is empty or being taken; the
    // request stage moves into it in the same cycle.
    assign rsp_adv   = !rsp_vld_reg || rsp.ready;
    assign fire      = req_vld_reg && rsp_adv;
    assign req.ready = !req_vld_reg || rsp_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            req_vld_reg <= 1'b0;
        else if (req.ready)
            req_vld_reg <= req.valid;
    end

    // Request payload: capture on acceptance, no reset needed.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            mode_reg       <= mode_t'(req.mode);
            pan_stick_reg  <= req.pan_stick;
            tilt_stick_reg <= req.tilt_stick;
        end
    end

    // Pan is steered in both steering modes, tilt only in pan-and-tilt mode.
    assign pan_en  = (mode_reg == MODE_PAN_TILT) || (mode_reg == MODE_PAN_ONLY);
    assign tilt_en = (mode_reg == MODE_PAN_TILT);

    gsrc_axis #(
        .STICK_BITS    (STICK_BITS),
        .POSITION_BITS (POSITION_BITS),
        .STEP_MED      (PAN_STEP_MED),
        .STEP_FAST     (PAN_STEP_FAST)
    ) u_pan_axis (
        .enable      (pan_en),
        .pos         (pan_now_reg),
        .stick       (pan_stick_reg),
        .center      (stick_center),
        .zone_small  (zone_small),
        .zone_medium (zone_medium),
        .pos_min     (pan_min),
        .pos_max     (pan_max),
        .pos_next    (pan_step_pos),
        .moved       (pan_moved)
    );

    gsrc_axis #(
        .STICK_BITS    (STICK_BITS),
        .POSITION_BITS (POSITION_BITS),
        .STEP_MED      (TILT_STEP_MED),
        .STEP_FAST     (TILT_STEP_FAST)
    ) u_tilt_axis (
        .enable      (tilt_en),
        .pos         (tilt_now_reg),
        .stick       (tilt_stick_reg),
        .center      (stick_center),
        .zone_small  (zone_small),
        .zone_medium (zone_medium),
        .pos_min     (tilt_min),
        .pos_max     (tilt_max),
        .pos_next    (tilt_step_pos),
        .moved       (tilt_moved)
    );

    // Home mode overrides the axis steps and always flags an update.
    always_comb
    begin
        if (mode_reg == MODE_HOME)
        begin
            pan_now_next  = home_position;
            tilt_now_next = home_position;
            updated_next  = 1'b1;
        end
        else
        begin
            pan_now_next  = pan_step_pos;
            tilt_now_next = tilt_step_pos;
            updated_next  = pan_moved || tilt_moved;
        end
    end

    // Servo state: update once per tick, as the tick moves into the result stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pan_now_reg  <= POSITION_BITS'(RST_HOME_POSITION);
            tilt_now_reg <= POSITION_BITS'(RST_HOME_POSITION);
        end
        else if (fire)
        begin
            pan_now_reg  <= pan_now_next;
            tilt_now_reg <= tilt_now_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_vld_reg <= 1'b0;
        else if (rsp_adv)
            rsp_vld_reg <= req_vld_reg;
    end

    // Result payload: hold while the result side stalls.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            pan_pos_reg  <= pan_now_next;
            tilt_pos_reg <= tilt_now_next;
            updated_reg  <= updated_next;
        end
    end

    assign rsp.valid            = rsp_vld_reg;
    assign rsp.pan_position     = pan_pos_reg;
    assign rsp.tilt_position    = tilt_pos_reg;
    assign rsp.position_updated = updated_reg;
endmodule

// File: src/gsrc_cfg_regs.sv
// Configuration register file of the gimbal stick rate control block.
// Depends on gsrc_pkg for register indexes and reset values.
module gsrc_cfg_regs #(
    parameter int STICK_BITS    = 11,
    parameter int POSITION_BITS = 12,
    parameter int DATA_BITS     = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [gsrc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [DATA_BITS-1:0]          cfg_data,
    output logic [STICK_BITS-1:0]         stick_center,
    output logic [STICK_BITS-1:0]         zone_small,
    output logic [STICK_BITS-1:0]         zone_medium,
    output logic [POSITION_BITS-1:0]      pan_min,
    output logic [POSITION_BITS-1:0]      pan_max,
    output logic [POSITION_BITS-1:0]      tilt_min,
    output logic [POSITION_BITS-1:0]      tilt_max,
    output logic [POSITION_BITS-1:0]      home_position
);
    import gsrc_pkg::*;

    logic [STICK_BITS-1:0]    stick_center_reg, zone_small_reg, zone_medium_reg;
    logic [POSITION_BITS-1:0] pan_min_reg, pan_max_reg, tilt_min_reg, tilt_max_reg;
    logic [POSITION_BITS-1:0] home_position_reg;
    logic [STICK_BITS-1:0]    data_stick;
    logic [POSITION_BITS-1:0] data_pos;

    assign data_stick = cfg_data[STICK_BITS-1:0];
    assign data_pos   = cfg_data[POSITION_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stick_center_reg  <= STICK_BITS'(RST_STICK_CENTER);
            zone_small_reg    <= STICK_BITS'(RST_ZONE_SMALL);
            zone_medium_reg   <= STICK_BITS'(RST_ZONE_MEDIUM);
            pan_min_reg       <= POSITION_BITS'(RST_PAN_MIN);
            pan_max_reg       <= POSITION_BITS'(RST_PAN_MAX);
            tilt_min_reg      <= POSITION_BITS'(RST_TILT_MIN);
            tilt_max_reg      <= POSITION_BITS'(RST_TILT_MAX);
            home_position_reg <= POSITION_BITS'(RST_HOME_POSITION);
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_STICK_CENTER:  stick_center_reg  <= data_stick;
                REG_ZONE_SMALL:    zone_small_reg    <= data_stick;
                REG_ZONE_MEDIUM:   zone_medium_reg   <= data_stick;
                REG_PAN_MIN:       pan_min_reg       <= data_pos;
                REG_PAN_MAX:       pan_max_reg       <= data_pos;
                REG_TILT_MIN:      tilt_min_reg      <= data_pos;
                REG_TILT_MAX:      tilt_max_reg      <= data_pos;
                REG_HOME_POSITION: home_position_reg <= data_pos;
                default:           ;
            endcase
        end
    end

    assign stick_center  = stick_center_reg;
    assign zone_small    = zone_small_reg;
    assign zone_medium   = zone_medium_reg;
    assign pan_min       = pan_min_reg;
    assign pan_max       = pan_max_reg;
    assign tilt_min      = tilt_min_reg;
    assign tilt_max      = tilt_max_reg;
    assign home_position = home_position_reg;
endmodule

// File: src/gsrc_axis.sv
// One axis step of the gimbal stick rate control block: zone, step and clamp.
// Depends on gsrc_pkg for the step width and the slow step size.
module gsrc_axis #(
    parameter int STICK_BITS    = 11,
    parameter int POSITION_BITS = 12,
    parameter int STEP_MED      = 18,
    parameter int STEP_FAST     = 50
) (
    input  logic                     enable,
    input  logic [POSITION_BITS-1:0] pos,
    input  logic [STICK_BITS-1:0]    stick,
    input  logic [STICK_BITS-1:0]    center,
    input  logic [STICK_BITS-1:0]    zone_small,
    input  logic [STICK_BITS-1:0]    zone_medium,
    input  logic [POSITION_BITS-1:0] pos_min,
    input  logic [POSITION_BITS-1:0] pos_max,
    output logic [POSITION_BITS-1:0] pos_next,
    output logic                     moved
);
    import gsrc_pkg::*;

    logic                     below;
    logic                     off_center;
    logic [STICK_BITS-1:0]    dev;
    logic [STEP_BITS-1:0]     step;
    logic [POSITION_BITS-1:0] step_ext;
    logic [POSITION_BITS:0]   sum;
    logic [POSITION_BITS-1:0] diff;
    logic [POSITION_BITS-1:0] rise_pos;
    logic [POSITION_BITS-1:0] fall_pos;

    assign below      = stick < center;
    assign off_center = stick != center;
    assign dev        = below ? (center - stick) : (stick - center);

    always_comb
    begin
        if (dev <= zone_small)
            step = STEP_BITS'(STEP_SLOW);
        else if (dev <= zone_medium)
            step = STEP_BITS'(STEP_MED);
        else
            step = STEP_BITS'(STEP_FAST);
    end

    assign step_ext = {{(POSITION_BITS-STEP_BITS){1'b0}}, step};
    assign sum      = {1'b0, pos} + {1'b0, step_ext};
    assign diff     = (pos > step_ext) ? (pos - step_ext) : '0;
    assign rise_pos = (sum > {1'b0, pos_max}) ? pos_max : sum[POSITION_BITS-1:0];
    assign fall_pos = (diff < pos_min) ? pos_min : diff;

    // Rise when the stick sits below center, fall when above.
    assign moved    = enable && off_center;
    assign pos_next = !moved ? pos : (below ? rise_pos : fall_pos);
endmodule

// File: verif/tb_gimbal_stick_rate_control.sv
// Self-checking testbench for gimbal_stick_rate_control: random and directed ticks,
// a running model of the servo positions, and random stalls on both channels.
// Depends on gsrc_pkg, gsrc_req_if, gsrc_rsp_if and the block's top level.
module tb_gimbal_stick_rate_control;
    timeunit 1ns;
    timeprecision 1ps;

    import gsrc_pkg::*;

    localparam int STICK_W   = 11;
    localparam int POS_W     = 12;
    localparam int CFG_W     = (STICK_W > POS_W) ? STICK_W : POS_W;
    localparam int STICK_MAX = (1 << STICK_W) - 1;
    localparam int POS_MAX   = (1 << POS_W) - 1;

    // One result as the block should produce it.
    typedef struct {
        logic [POS_W-1:0] pan;
        logic [POS_W-1:0] tilt;
        logic             moved;
    } servo_cmd_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_wr_en;
    cfg_index_t       cfg_index;
    logic [CFG_W-1:0] cfg_data;

    gsrc_req_if #(.STICK_BITS(STICK_W))    req ();
    gsrc_rsp_if #(.POSITION_BITS(POS_W))   rsp ();

    gimbal_stick_rate_control #(
        .STICK_BITS    (STICK_W),
        .POSITION_BITS (POS_W)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Our own copy of the register file and of the two servo positions.
    int               cfg_shadow [8];
    logic [POS_W-1:0] pan_now;
    logic [POS_W-1:0] tilt_now;

    // Results still owed by the block, oldest first.
    servo_cmd_t       servo_cmd_q [$];

    int               mismatch_count = 0;
    // Random idling on both channels; cleared for the last part of the run.
    bit               idle_on = 1'b1;
    // Long receiver hold-off, set by a test and counted down by the result sink.
    int               hold_off_left = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Position model
    // ------------------------------------------------------------------

    // Move one axis by its stick; returns 1 when the stick is off centre.
    // Both axes rise while their stick is below centre. A rise clamps to the
    // maximum only; a fall saturates at zero and is then lifted to the minimum.
    function automatic bit steer_axis(inout logic [POS_W-1:0] pos, input int stick,
                                      input bit pan_axis, input int lo, input int hi);
        int center;
        int dev;
        int step;
        int p;
        bit below;
        center = cfg_shadow[REG_STICK_CENTER];
        if (stick == center)
            return 1'b0;
        below = stick < center;
        dev   = below ? center - stick : stick - center;
        if (dev <= cfg_shadow[REG_ZONE_SMALL])
            step = STEP_SLOW;
        else if (dev <= cfg_shadow[REG_ZONE_MEDIUM])
            step = pan_axis ? PAN_STEP_MED : TILT_STEP_MED;
        else
            step = pan_axis ? PAN_STEP_FAST : TILT_STEP_FAST;
        p = pos;
        if (below)
        begin
            p = p + step;
            if (p > hi)
                p = hi;
        end
        else
        begin
            p = (p > step) ? p - step : 0;
            if (p < lo)
                p = lo;
        end
        pos = p[POS_W-1:0];
        return 1'b1;
    endfunction

    // Advance the model by one accepted request and return the result it owes.
    function automatic servo_cmd_t apply_tick(mode_t m, int ps, int ts);
        servo_cmd_t cmd;
        bit         moved;
        moved = 1'b0;
        case (m)
            MODE_HOME:
            begin
                pan_now  = cfg_shadow[REG_HOME_POSITION];
                tilt_now = cfg_shadow[REG_HOME_POSITION];
                moved    = 1'b1;
            end
            MODE_PAN_TILT, MODE_PAN_ONLY:
            begin
                moved = steer_axis(pan_now, ps, 1'b1, cfg_shadow[REG_PAN_MIN],
                                   cfg_shadow[REG_PAN_MAX]);
                if (m == MODE_PAN_TILT)
                    moved |= steer_axis(tilt_now, ts, 1'b0, cfg_shadow[REG_TILT_MIN],
                                        cfg_shadow[REG_TILT_MAX]);
            end
            default: ;
        endcase
        cmd.pan   = pan_now;
        cmd.tilt  = tilt_now;
        cmd.moved = moved;
        return cmd;
    endfunction

    // ------------------------------------------------------------------
    // Random request content
    // ------------------------------------------------------------------

    // Hold and home are rarer so that positions get time to wander to the limits.
    function automatic mode_t pick_mode();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return MODE_HOLD;
        if (sel == 1)
            return MODE_HOME;
        if (sel < 6)
            return MODE_PAN_TILT;
        return MODE_PAN_ONLY;
    endfunction

    // Mostly readings around the current centre, with zone edges hit on purpose,
    // plus exact centre and readings from the whole range.
    function automatic int pick_stick();
        int c;
        int d;
        int v;
        c = cfg_shadow[REG_STICK_CENTER];
        case ($urandom_range(0, 9))
            0: return c;
            1, 2: return $urandom_range(0, STICK_MAX);
            3:
            begin
                case ($urandom_range(0, 3))
                    0: d = cfg_shadow[REG_ZONE_SMALL];
                    1: d = cfg_shadow[REG_ZONE_SMALL] + 1;
                    2: d = cfg_shadow[REG_ZONE_MEDIUM];
                    default: d = cfg_shadow[REG_ZONE_MEDIUM] + 1;
                endcase
            end
            default: d = $urandom_range(0, cfg_shadow[REG_ZONE_MEDIUM] + 64);
        endcase
        v = $urandom_range(0, 1) ? c + d : c - d;
        if (v < 0 || v > STICK_MAX)
            v = $urandom_range(0, STICK_MAX);
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what);
        mismatch_count++;
        $display("MISMATCH at %0t: %s", $time, what);
    endtask

    task automatic check_result();
        servo_cmd_t want;
        if (servo_cmd_q.size() == 0)
        begin
            report_mismatch("result with no request pending");
            return;
        end
        want = servo_cmd_q.pop_front();
        if (rsp.pan_position !== want.pan)
            report_mismatch($sformatf("pan_position got %0d want %0d",
                                      rsp.pan_position, want.pan));
        if (rsp.tilt_position !== want.tilt)
            report_mismatch($sformatf("tilt_position got %0d want %0d",
                                      rsp.tilt_position, want.tilt));
        if (rsp.position_updated !== want.moved)
            report_mismatch($sformatf("position_updated got %0b want %0b",
                                      rsp.position_updated, want.moved));
    endtask

    // Result side: take results, stall in random bursts, and serve a long
    // hold-off whenever a test asks for one. A result is checked at the falling
    // edge before the rising edge that takes it, while the channel is steady.
    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (rst_n && rsp.valid && rsp.ready)
                check_result();
            @(posedge clk);
            if (hold_off_left > 0)
            begin
                rsp.ready <= 1'b0;
                hold_off_left--;
            end
            else if (stall_left > 0)
            begin
                rsp.ready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                rsp.ready <= 1'b0;
                stall_left = $urandom_range(0, 6);
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    // Offer one request and hold it until taken. Valid is left high so that
    // back-to-back requests need no drop; a random gap lowers it first.
    // Ready is sampled at the falling edge, before the edge that takes the request.
    task automatic send_tick(mode_t m, int ps, int ts);
        bit taken;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        req.valid      <= 1'b1;
        req.mode       <= m;
        req.pan_stick  <= ps[STICK_W-1:0];
        req.tilt_stick <= ts[STICK_W-1:0];
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = req.ready;
            @(posedge clk);
        end
        servo_cmd_q.push_back(apply_tick(m, ps, ts));
    endtask

    // Drop valid and wait until every owed result is in, then let the
    // pipeline settle.
    task automatic wait_results_drained();
        int guard;
        guard = 0;
        req.valid <= 1'b0;
        while (servo_cmd_q.size() != 0 && guard < 5000)
        begin
            @(posedge clk);
            guard++;
        end
        if (servo_cmd_q.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", servo_cmd_q.size()));
            servo_cmd_q.delete();
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(cfg_index_t idx, int value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_W-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        // Stick registers keep only their low STICK_W bits.
        cfg_shadow[idx] = (idx < REG_PAN_MIN) ? (value & STICK_MAX) : (value & POS_MAX);
    endtask

    // Drain the block, then rewrite the whole register file.
    task automatic set_config(int center, int z_slow, int z_mid, int pan_lo, int pan_hi,
                              int tilt_lo, int tilt_hi, int home);
        wait_results_drained();
        write_reg(REG_STICK_CENTER, center);
        write_reg(REG_ZONE_SMALL, z_slow);
        write_reg(REG_ZONE_MEDIUM, z_mid);
        write_reg(REG_PAN_MIN, pan_lo);
        write_reg(REG_PAN_MAX, pan_hi);
        write_reg(REG_TILT_MIN, tilt_lo);
        write_reg(REG_TILT_MAX, tilt_hi);
        write_reg(REG_HOME_POSITION, home);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset settings: every mode, every pan step zone in both directions, zone edges.
    task automatic test_default_steering();
        send_tick(MODE_HOLD, 1024, 1024);
        send_tick(MODE_PAN_ONLY, 1024 - 100, 1024);
        send_tick(MODE_PAN_ONLY, 1024 + 100, 0);
        send_tick(MODE_PAN_ONLY, 1024 - 300, 2047);
        send_tick(MODE_PAN_ONLY, 1024 + 300, 1024);
        send_tick(MODE_PAN_ONLY, 0, 1024);
        send_tick(MODE_PAN_ONLY, STICK_MAX, 1024);
        // Pan at centre: nothing moves and the flag stays low.
        send_tick(MODE_PAN_ONLY, 1024, 0);
        send_tick(MODE_PAN_TILT, 1024, 1024 - 100);
        send_tick(MODE_PAN_TILT, 1024, 1024 + 300);
        send_tick(MODE_PAN_TILT, STICK_MAX, 0);
        send_tick(MODE_PAN_TILT, 1024 - 220, 1024 + 220);
        send_tick(MODE_PAN_TILT, 1024 - 221, 1024 + 221);
        send_tick(MODE_PAN_TILT, 1024 - 440, 1024 + 441);
        send_tick(MODE_HOME, 0, STICK_MAX);
        // Hold ignores the sticks entirely.
        send_tick(MODE_HOLD, 0, STICK_MAX);
    endtask

    // Register extremes, saturation at zero, inverted limits and zones.
    task automatic test_limits_and_odd_settings();
        // Fall below zero saturates there; the floor is zero too.
        set_config(1024, 220, 440, 0, POS_MAX, 0, POS_MAX, 2);
        send_tick(MODE_HOME, 1024, 1024);
        send_tick(MODE_PAN_TILT, STICK_MAX, STICK_MAX);
        send_tick(MODE_PAN_TILT, 1100, 1100);
        // Rise clamps at the top of the position range.
        set_config(1024, 220, 440, 0, POS_MAX, 0, POS_MAX, POS_MAX);
        send_tick(MODE_HOME, 1024, 1024);
        send_tick(MODE_PAN_TILT, 0, 0);
        // Minimum above maximum: rises clamp down, falls get lifted.
        set_config(1024, 220, 440, 3000, 1000, 2500, 2000, 2000);
        send_tick(MODE_HOME, 1024, 1024);
        send_tick(MODE_PAN_TILT, 0, 0);
        send_tick(MODE_PAN_TILT, STICK_MAX, STICK_MAX);
        send_tick(MODE_PAN_ONLY, 0, STICK_MAX);
        // Fully inverted extremes.
        set_config(1024, 220, 440, POS_MAX, 0, POS_MAX, 0, 0);
        send_tick(MODE_HOME, 1024, 1024);
        send_tick(MODE_PAN_TILT, 0, 0);
        send_tick(MODE_PAN_TILT, STICK_MAX, STICK_MAX);
        // Medium zone narrower than the slow zone.
        set_config(1024, 500, 100, 500, 2250, 1000, 2100, 1350);
        send_tick(MODE_PAN_TILT, 1024 - 50, 1024 + 50);
        send_tick(MODE_PAN_TILT, 1024 - 300, 1024 + 300);
        send_tick(MODE_PAN_TILT, 1024 - 600, 1024 + 600);
        // Zones at both ends of their range.
        set_config(1024, 0, 0, 500, 2250, 1000, 2100, 1350);
        send_tick(MODE_PAN_TILT, 1023, 1025);
        set_config(1024, STICK_MAX, STICK_MAX, 500, 2250, 1000, 2100, 1350);
        send_tick(MODE_PAN_TILT, 0, STICK_MAX);
        // Centre at each end of the stick range.
        set_config(0, 220, 440, 500, 2250, 1000, 2100, 1350);
        send_tick(MODE_PAN_TILT, 0, 0);
        send_tick(MODE_PAN_TILT, 1, STICK_MAX);
        set_config(STICK_MAX, 220, 440, 500, 2250, 1000, 2100, 1350);
        send_tick(MODE_PAN_TILT, STICK_MAX, STICK_MAX);
        send_tick(MODE_PAN_TILT, 0, STICK_MAX - 1);
        // Only the low bits of a centre write count: this lands on 1024.
        set_config(12'hC00, 220, 440, 500, 2250, 1000, 2100, 1350);
        send_tick(MODE_PAN_TILT, 1024, 1024);
        send_tick(MODE_PAN_TILT, 1024 - 10, 1024 + 10);
    endtask

    // Several random register settings, each followed by a run of random ticks.
    task automatic test_random_settings();
        int c;
        int zs;
        int zm;
        int plo;
        int phi;
        int tlo;
        int thi;
        int hm;
        for (int phase = 0; phase < 8; phase++)
        begin
            if ($urandom_range(0, 5) == 0)
                c = $urandom_range(0, 1) ? 0 : STICK_MAX;
            else
                c = $urandom_range(0, STICK_MAX);
            zs = $urandom_range(0, 500);
            zm = zs + $urandom_range(0, 500);
            if ($urandom_range(0, 7) == 0)
                zm = $urandom_range(0, zs);
            // Narrow windows drive positions into the clamps quickly.
            plo = $urandom_range(0, 3500);
            phi = plo + $urandom_range(0, $urandom_range(0, 1) ? 300 : POS_MAX - plo);
            tlo = $urandom_range(0, 3500);
            thi = tlo + $urandom_range(0, $urandom_range(0, 1) ? 300 : POS_MAX - tlo);
            if ($urandom_range(0, 9) == 0)
            begin
                hm  = plo;
                plo = phi;
                phi = hm;
            end
            hm = $urandom_range(0, 1) ? $urandom_range(plo, phi) : $urandom_range(0, POS_MAX);
            set_config(c, zs, zm, plo, phi, tlo, thi, hm);
            repeat (140)
                send_tick(pick_mode(), pick_stick(), pick_stick());
        end
    endtask

    // Hold the result side off long enough that the block fills and stalls
    // its request side, then pause the sender until everything has come out.
    task automatic test_result_backpressure();
        set_config(1024, 220, 440, 500, 2250, 1000, 2100, 1350);
        hold_off_left = 60;
        repeat (16)
            send_tick(pick_mode(), pick_stick(), pick_stick());
        wait_results_drained();
        repeat (20)
            send_tick(pick_mode(), pick_stick(), pick_stick());
    endtask

    // Back-to-back requests with the result side always ready.
    task automatic test_steady_stream();
        wait_results_drained();
        idle_on = 1'b0;
        repeat (250)
            send_tick(pick_mode(), pick_stick(), pick_stick());
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial
    begin
        cfg_shadow[REG_STICK_CENTER]  = RST_STICK_CENTER;
        cfg_shadow[REG_ZONE_SMALL]    = RST_ZONE_SMALL;
        cfg_shadow[REG_ZONE_MEDIUM]   = RST_ZONE_MEDIUM;
        cfg_shadow[REG_PAN_MIN]       = RST_PAN_MIN;
        cfg_shadow[REG_PAN_MAX]       = RST_PAN_MAX;
        cfg_shadow[REG_TILT_MIN]      = RST_TILT_MIN;
        cfg_shadow[REG_TILT_MAX]      = RST_TILT_MAX;
        cfg_shadow[REG_HOME_POSITION] = RST_HOME_POSITION;
        // Positions come out of reset at home regardless of the home register.
        pan_now  = RST_HOME_POSITION;
        tilt_now = RST_HOME_POSITION;

        rst_n          <= 1'b0;
        cfg_wr_en      <= 1'b0;
        cfg_index      <= REG_STICK_CENTER;
        cfg_data       <= '0;
        req.valid      <= 1'b0;
        req.mode       <= MODE_HOLD;
        req.pan_stick  <= '0;
        req.tilt_stick <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_steering();
        test_limits_and_odd_settings();
        test_random_settings();
        test_result_backpressure();
        test_steady_stream();

        wait_results_drained();
        if (mismatch_count == 0)
            $display("tb_gimbal_stick_rate_control OK");
        else
            $display("tb_gimbal_stick_rate_control NOT OK");
        $finish;
    end

    // Watchdog: a correct run ends far sooner than this.
    initial
    begin
        #(5_000_000);
        $display("tb_gimbal_stick_rate_control NOT OK");
        $finish;
    end

endmodule

// File: filelist.f
src/gsrc_pkg.sv
src/gsrc_req_if.sv
src/gsrc_rsp_if.sv
src/gsrc_cfg_regs.sv
src/gsrc_axis.sv
src/gimbal_stick_rate_control.sv
verif/tb_gimbal_stick_rate_control.sv
